// ----- rtl/core/ptc_pkg.sv -----
// Shared types, codes and constants for the pre/post trigger capture block.
`timescale 1ns / 1ps

package ptc_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int RADDR_W  = 12;
  localparam int PHASE_W  = 2;
  localparam int WPOS_W   = 10;
  localparam int COUNT_W  = 24;
  localparam int MEM_AW   = 16;   // covers the largest store depth

  localparam int IN_TDATA_W  = 24;  // sample, read_address
  localparam int OUT_TDATA_W = 48;  // phase, read_data, write_position, detect_count

  // Configuration registers
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_ARM_THRESHOLD     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_THRESHOLD = 1'd1;
  localparam logic [SAMPLE_W-1:0] ARM_THRESHOLD_RESET     = 12'd100;
  localparam logic [SAMPLE_W-1:0] TRIGGER_THRESHOLD_RESET = 12'd3500;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Request kind carried on tuser
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Phase codes seen on the output
  localparam logic [PHASE_W-1:0] CODE_ARMING = 2'd0;
  localparam logic [PHASE_W-1:0] CODE_DETECT = 2'd1;
  localparam logic [PHASE_W-1:0] CODE_POST   = 2'd2;
  localparam logic [PHASE_W-1:0] CODE_DONE   = 2'd3;

  // Capture sequencer states
  typedef enum logic [3:0] {
    PH_ARMING = 4'b0001,
    PH_DETECT = 4'b0010,
    PH_POST   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Memory operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_WR_PRE  = 3'd1,
    OP_WR_POST = 3'd2,
    OP_RD_PRE  = 3'd3,
    OP_RD_POST = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [MEM_AW-1:0]     addr;
    logic [SAMPLE_W-1:0]   data;
    logic [PHASE_W-1:0]    phase;
    logic [WPOS_W-1:0]     wpos;
    logic [COUNT_W-1:0]    count;
  } op_t;

  localparam int QUEUE_DEPTH = 4;

  function automatic logic [PHASE_W-1:0] phase_code(phase_t ph);
    logic [PHASE_W-1:0] code;
    code = CODE_ARMING;
    unique case (ph)
      PH_ARMING: code = CODE_ARMING;
      PH_DETECT: code = CODE_DETECT;
      PH_POST:   code = CODE_POST;
      PH_DONE:   code = CODE_DONE;
      default:   code = CODE_ARMING;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/ptc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ptc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/ptc_front.sv -----
// Front end: config registers, capture sequencer, request classification.
`timescale 1ns / 1ps

module ptc_front #(
  parameter int PRE_DEPTH  = 1024,
  parameter int POST_DEPTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ptc_pkg::SAMPLE_W-1:0]        cfg_data,
  input  logic                                accept,
  input  logic                                func,
  input  logic [ptc_pkg::SAMPLE_W-1:0]        sample,
  input  logic [ptc_pkg::RADDR_W-1:0]         read_address,
  output ptc_pkg::op_t                        op
);

  localparam int PP_W  = $clog2(PRE_DEPTH);
  localparam int PI_W  = $clog2(POST_DEPTH + 1);
  localparam int SPAN_W = $clog2(PRE_DEPTH + POST_DEPTH + 1);
  localparam int RA_W  = (SPAN_W > ptc_pkg::RADDR_W) ? SPAN_W : ptc_pkg::RADDR_W;

  logic [ptc_pkg::SAMPLE_W-1:0] arm_threshold;
  logic [ptc_pkg::SAMPLE_W-1:0] trigger_threshold;

  ptc_pkg::phase_t              phase, phase_next;
  logic [PP_W-1:0]              pre_pointer, pre_pointer_next;
  logic                         pre_wrapped, pre_wrapped_next;
  logic [PI_W-1:0]              post_index, post_index_next;
  logic [ptc_pkg::COUNT_W-1:0]  sample_count, sample_count_next;

  logic [RA_W-1:0]              ra;
  logic [RA_W-1:0]              post_off;
  ptc_pkg::op_kind_t            kind;
  logic [ptc_pkg::MEM_AW-1:0]   mem_addr;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      arm_threshold     <= ptc_pkg::ARM_THRESHOLD_RESET;
      trigger_threshold <= ptc_pkg::TRIGGER_THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ptc_pkg::REG_ARM_THRESHOLD:     arm_threshold     <= cfg_data;
        ptc_pkg::REG_TRIGGER_THRESHOLD: trigger_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ra       = RA_W'(read_address);
  assign post_off = ra - RA_W'(PRE_DEPTH);

  // Sequencer next state and memory request
  always_comb begin
    phase_next        = phase;
    pre_pointer_next  = pre_pointer;
    pre_wrapped_next  = pre_wrapped;
    post_index_next   = post_index;
    sample_count_next = sample_count;
    kind              = ptc_pkg::OP_NONE;
    mem_addr          = '0;
    if (func == ptc_pkg::FUNC_READ) begin
      // unwritten entries read as zero, so they issue no RAM read
      if (ra < RA_W'(PRE_DEPTH)) begin
        if (pre_wrapped || (ra < RA_W'(pre_pointer))) begin
          kind     = ptc_pkg::OP_RD_PRE;
          mem_addr = ptc_pkg::MEM_AW'(ra);
        end
      end else if (post_off < RA_W'(POST_DEPTH)) begin
        if (post_off < RA_W'(post_index)) begin
          kind     = ptc_pkg::OP_RD_POST;
          mem_addr = ptc_pkg::MEM_AW'(post_off);
        end
      end
    end else begin
      unique case (phase)
        ptc_pkg::PH_ARMING: begin
          if (sample <= arm_threshold) begin
            phase_next = ptc_pkg::PH_DETECT;
          end
        end
        ptc_pkg::PH_DETECT: begin
          if (sample_count != ptc_pkg::COUNT_MAX) begin
            sample_count_next = sample_count + 1'b1;
          end
          kind     = ptc_pkg::OP_WR_PRE;
          mem_addr = ptc_pkg::MEM_AW'(pre_pointer);
          if (pre_pointer == PP_W'(PRE_DEPTH - 1)) begin
            pre_pointer_next = '0;
            pre_wrapped_next = 1'b1;
          end else begin
            pre_pointer_next = pre_pointer + 1'b1;
          end
          if (sample >= trigger_threshold) begin
            phase_next = ptc_pkg::PH_POST;
          end
        end
        ptc_pkg::PH_POST: begin
          kind            = ptc_pkg::OP_WR_POST;
          mem_addr        = ptc_pkg::MEM_AW'(post_index);
          post_index_next = post_index + 1'b1;
          if (post_index == PI_W'(POST_DEPTH - 1)) begin
            phase_next = ptc_pkg::PH_DONE;
          end
        end
        ptc_pkg::PH_DONE: ;
        default: ;
      endcase
    end
  end

  // Request handed to the queue, result fields taken after the update
  always_comb begin
    op.kind  = kind;
    op.addr  = mem_addr;
    op.data  = sample;
    op.phase = ptc_pkg::phase_code(phase_next);
    op.wpos  = ptc_pkg::WPOS_W'(pre_pointer_next);
    op.count = sample_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ptc_pkg::PH_ARMING;
      pre_pointer  <= '0;
      pre_wrapped  <= 1'b0;
      post_index   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      pre_pointer  <= pre_pointer_next;
      pre_wrapped  <= pre_wrapped_next;
      post_index   <= post_index_next;
      sample_count <= sample_count_next;
    end
  end

endmodule

// ----- rtl/core/ptc_queue.sv -----
// Short FIFO of memory requests between front and back.
`timescale 1ns / 1ps

module ptc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ptc_pkg::op_t  push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output ptc_pkg::op_t  head
);

  localparam int PTR_W = $clog2(ptc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ptc_pkg::QUEUE_DEPTH + 1);

  ptc_pkg::op_t       slots [ptc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full      = (fill == CNT_W'(ptc_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/ptc_back.sv -----
// Back end: sample stores, read stage and output register.
`timescale 1ns / 1ps

module ptc_back #(
  parameter int PRE_DEPTH  = 1024,
  parameter int POST_DEPTH = 2048
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  ptc_pkg::op_t                          q_head,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ptc_pkg::OUT_TDATA_W-1:0]       m_tdata
);

  localparam int PRE_AW  = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
  localparam int POST_AW = (POST_DEPTH > 1) ? $clog2(POST_DEPTH) : 1;

  logic                          s1_valid;
  ptc_pkg::op_t                  s1;
  logic                          advance;
  logic [ptc_pkg::SAMPLE_W-1:0]  pre_dout;
  logic [ptc_pkg::SAMPLE_W-1:0]  post_dout;
  logic [ptc_pkg::SAMPLE_W-1:0]  read_data;

  // Stage moves when the output slot is free or being drained
  assign advance = s1_valid && (!m_tvalid || m_tready);
  assign q_pop   = q_valid && (!s1_valid || advance);

  ptc_ram #(.WIDTH(ptc_pkg::SAMPLE_W), .DEPTH(PRE_DEPTH)) u_pre_ram (
    .clk     (clk),
    .wr_en   (q_pop && (q_head.kind == ptc_pkg::OP_WR_PRE)),
    .wr_addr (PRE_AW'(q_head.addr)),
    .wr_data (q_head.data),
    .rd_en   (q_pop && (q_head.kind == ptc_pkg::OP_RD_PRE)),
    .rd_addr (PRE_AW'(q_head.addr)),
    .rd_data (pre_dout)
  );

  ptc_ram #(.WIDTH(ptc_pkg::SAMPLE_W), .DEPTH(POST_DEPTH)) u_post_ram (
    .clk     (clk),
    .wr_en   (q_pop && (q_head.kind == ptc_pkg::OP_WR_POST)),
    .wr_addr (POST_AW'(q_head.addr)),
    .wr_data (q_head.data),
    .rd_en   (q_pop && (q_head.kind == ptc_pkg::OP_RD_POST)),
    .rd_addr (POST_AW'(q_head.addr)),
    .rd_data (post_dout)
  );

  // Memory access stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= q_head;
    end
  end

  // Pick read data; sample requests and unwritten entries give zero
  always_comb begin
    unique case (s1.kind)
      ptc_pkg::OP_RD_PRE:  read_data = pre_dout;
      ptc_pkg::OP_RD_POST: read_data = post_dout;
      default:             read_data = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {s1.count, s1.wpos, read_data, s1.phase};
    end
  end

endmodule

// ----- rtl/core/pre_post_trigger_capture_top.sv -----
// Top level of the pre/post trigger sample capture block.
// Use: the slave stream carries one request per beat. tuser = 0 is an ADC
// sample, tuser = 1 reads a stored word at read_address (pre store first,
// then post store). Every request gives exactly one master-stream beat with
// the phase, the read data (zero for samples), the next pre-store slot and
// the saturating detect count, all as they stand after that request.
// Thresholds are written through cfg_wr_en/cfg_index/cfg_data while idle;
// the user must keep to this, the block does not enforce it. Throughput:
// one request per cycle sustained while m_tready stays high; each sample
// needs at most one compare and one RAM write, each read at most one RAM
// read. A result passes the request queue, RAM read stage and output register.
// Reset: phase goes to arming, pointers and count clear, thresholds load
// 100 and 3500. Stores need no clearing pass: entries not yet written
// since reset read as zero, tracked by the write pointers.
// Stall: a four-entry queue plus the read stage and output register
// absorb receiver back-pressure; s_tready drops when the queue is full.
`timescale 1ns / 1ps

module pre_post_trigger_capture_top #(
  parameter int PRE_DEPTH  = 1024,
  parameter int POST_DEPTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ptc_pkg::SAMPLE_W-1:0]        cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ptc_pkg::IN_TDATA_W-1:0]      s_tdata,   // sample, read_address
  input  logic                                s_tuser,   // func
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ptc_pkg::OUT_TDATA_W-1:0]     m_tdata    // phase, read_data,
                                                         // write_position, detect_count
);

  logic          accept;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  ptc_pkg::op_t  front_op;
  ptc_pkg::op_t  q_head;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  ptc_front #(.PRE_DEPTH(PRE_DEPTH), .POST_DEPTH(POST_DEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .func         (s_tuser),
    .sample       (s_tdata[11:0]),
    .read_address (s_tdata[23:12]),
    .op           (front_op)
  );

  ptc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_op),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  ptc_back #(.PRE_DEPTH(PRE_DEPTH), .POST_DEPTH(POST_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/core/ptc_checker.sv -----
// Port-level checks for the capture block, bound to the top level.
`timescale 1ns / 1ps

module ptc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ptc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  // No result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // While arming nothing has been counted or stored
  a_arming_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ptc_pkg::CODE_ARMING)
      |-> (m_tdata[47:24] == '0) && (m_tdata[23:14] == '0))
    else $error("arming result shows detect activity");

  // Post capture or done implies the trigger sample was counted
  a_trigger_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tdata[1:0] == ptc_pkg::CODE_POST) ||
                 (m_tdata[1:0] == ptc_pkg::CODE_DONE))
      |-> (m_tdata[47:24] != '0))
    else $error("post phase with zero detect count");

endmodule

bind pre_post_trigger_capture_top ptc_checker u_ptc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
